/* design/integer_stack_machine_defines.svh */
// Assertion macros used by the checker file of the integer stack machine.
`ifndef INTEGER_STACK_MACHINE_DEFINES_SVH
`define INTEGER_STACK_MACHINE_DEFINES_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define ISM_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("integer_stack_machine assertion failed");

// Clocked assertion on the block's own clock and reset.
`define ISM_ASSERT(lbl, prop) `ISM_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

/* design/ism_pkg.sv */
// Shared types and codes of the integer stack machine.
package ism_pkg;

    localparam int unsigned DataW = 32;

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_PALL = 3'd1,
        OP_POP  = 3'd2,
        OP_PINT = 3'd3,
        OP_ADD  = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_PINT_EMPTY = 3'd1,
        ERR_POP_EMPTY  = 3'd2,
        ERR_ADD_SHORT  = 3'd3,
        ERR_PUSH_FULL  = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OUT,
        S_ADD,
        S_ERR,
        S_HALT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;       // write the pushed value at the top and count up
        logic rd_top;     // read the top entry (and the one below it)
        logic rd_next;    // read the entry below the print pointer, step pointer down
        logic ptr_top;    // load the print pointer with the top index
        logic ptr_clear;  // load the print pointer with zero
        logic add_wb;     // write the sum of the two read entries, count down
        logic pop;        // count down
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic two_plus;
        logic ptr_zero;
    } t_status;

endpackage

/* design/ism_datapath.sv */
// Datapath of the integer stack machine: stack memory, entry count, print pointer, adder.
module ism_datapath #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ism_pkg::t_cmd                        i_cmd,
    input  logic signed [ism_pkg::DataW-1:0]     i_push_value,
    output ism_pkg::t_status                     o_status,
    output logic signed [ism_pkg::DataW-1:0]     o_rd_data
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [ism_pkg::DataW-1:0] r_mem [DEPTH];
    logic [ism_pkg::DataW-1:0] r_rd_a;
    logic [ism_pkg::DataW-1:0] r_rd_b;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [AW-1:0]             r_ptr;
    logic [AW-1:0]             n_ptr;

    logic [CW-1:0]             top_idx;
    logic [CW-1:0]             below_idx;
    logic [AW-1:0]             rd_addr_a;
    logic [AW-1:0]             wr_addr;
    logic [ism_pkg::DataW-1:0] wr_data;
    logic                      wr_en;
    logic                      rd_en;

    assign top_idx   = r_count - CW'(1);
    assign below_idx = r_count - CW'(2);
    assign rd_en     = i_cmd.rd_top | i_cmd.rd_next;
    assign rd_addr_a = i_cmd.rd_next ? (r_ptr - AW'(1)) : top_idx[AW-1:0];

    assign wr_en     = i_cmd.push | i_cmd.add_wb;
    assign wr_addr   = i_cmd.add_wb ? below_idx[AW-1:0] : r_count[AW-1:0];
    assign wr_data   = i_cmd.add_wb ? (r_rd_a + r_rd_b) : i_push_value;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= r_mem[rd_addr_a];
            r_rd_b <= r_mem[below_idx[AW-1:0]];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop | i_cmd.add_wb) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.ptr_top) begin
            n_ptr = top_idx[AW-1:0];
        end else if (i_cmd.ptr_clear) begin
            n_ptr = '0;
        end else if (i_cmd.rd_next) begin
            n_ptr = r_ptr - AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
        end else begin
            r_count <= n_count;
            r_ptr   <= n_ptr;
        end
    end

    assign o_status.empty    = (r_count == '0);
    assign o_status.full     = (r_count == CW'(DEPTH));
    assign o_status.two_plus = (r_count >= CW'(2));
    assign o_status.ptr_zero = (r_ptr == '0);
    assign o_rd_data         = r_rd_a;

endmodule

/* design/ism_controller.sv */
// Controller state machine of the integer stack machine.
module ism_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [2:0]           i_opcode,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  ism_pkg::t_status     i_status,
    output ism_pkg::t_cmd        o_cmd,
    output logic                 o_is_error,
    output logic [2:0]           o_error_code,
    output logic                 o_last
);

    ism_pkg::t_state r_state;
    ism_pkg::t_state n_state;
    ism_pkg::t_err   r_err;
    ism_pkg::t_err   n_err;
    logic            in_acc;
    logic            out_acc;

    assign in_acc  = i_in_valid & o_in_ready;
    assign out_acc = o_out_valid & i_out_ready;

    // Next state and error code.
    always_comb begin
        n_state = r_state;
        n_err   = r_err;
        unique case (r_state)
            ism_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (i_opcode)
                        ism_pkg::OP_PUSH: begin
                            if (i_status.full) begin
                                n_state = ism_pkg::S_ERR;
                                n_err   = ism_pkg::ERR_PUSH_FULL;
                            end
                        end
                        ism_pkg::OP_PALL: begin
                            if (!i_status.empty) begin
                                n_state = ism_pkg::S_OUT;
                            end
                        end
                        ism_pkg::OP_POP: begin
                            if (i_status.empty) begin
                                n_state = ism_pkg::S_ERR;
                                n_err   = ism_pkg::ERR_POP_EMPTY;
                            end
                        end
                        ism_pkg::OP_PINT: begin
                            if (i_status.empty) begin
                                n_state = ism_pkg::S_ERR;
                                n_err   = ism_pkg::ERR_PINT_EMPTY;
                            end else begin
                                n_state = ism_pkg::S_OUT;
                            end
                        end
                        ism_pkg::OP_ADD: begin
                            if (!i_status.two_plus) begin
                                n_state = ism_pkg::S_ERR;
                                n_err   = ism_pkg::ERR_ADD_SHORT;
                            end else begin
                                n_state = ism_pkg::S_ADD;
                            end
                        end
                        default: begin
                            n_state = ism_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            ism_pkg::S_OUT: begin
                if (out_acc && i_status.ptr_zero) begin
                    n_state = ism_pkg::S_IDLE;
                end
            end
            ism_pkg::S_ADD: begin
                n_state = ism_pkg::S_IDLE;
            end
            ism_pkg::S_ERR: begin
                if (out_acc) begin
                    n_state = ism_pkg::S_HALT;
                end
            end
            ism_pkg::S_HALT: begin
                n_state = ism_pkg::S_HALT;
            end
            default: begin
                n_state = ism_pkg::S_HALT;
            end
        endcase
    end

    // Outputs and datapath commands. Ready is high throughout the idle state,
    // so an input item is taken there whenever valid is high.
    always_comb begin
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_is_error   = 1'b0;
        o_error_code = ism_pkg::ERR_NONE;
        o_last       = 1'b0;
        unique case (r_state)
            ism_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_opcode)
                        ism_pkg::OP_PUSH: o_cmd.push = !i_status.full;
                        ism_pkg::OP_PALL: begin
                            o_cmd.rd_top  = !i_status.empty;
                            o_cmd.ptr_top = !i_status.empty;
                        end
                        ism_pkg::OP_POP:  o_cmd.pop = !i_status.empty;
                        ism_pkg::OP_PINT: begin
                            o_cmd.rd_top    = !i_status.empty;
                            o_cmd.ptr_clear = !i_status.empty;
                        end
                        ism_pkg::OP_ADD:  o_cmd.rd_top = i_status.two_plus;
                        default:          o_cmd = '0;
                    endcase
                end
            end
            ism_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                o_last      = i_status.ptr_zero;
                o_cmd.rd_next = i_out_ready & !i_status.ptr_zero;
            end
            ism_pkg::S_ADD: begin
                o_cmd.add_wb = 1'b1;
            end
            ism_pkg::S_ERR: begin
                o_out_valid  = 1'b1;
                o_is_error   = 1'b1;
                o_error_code = r_err;
                o_last       = 1'b1;
            end
            ism_pkg::S_HALT: begin
                // Items keep being taken so the upstream side never hangs; all are dropped.
                o_in_ready = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ism_pkg::S_IDLE;
            r_err   <= ism_pkg::ERR_NONE;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
        end
    end

endmodule

/* design/integer_stack_machine.sv */
// Top level of the integer stack machine: controller plus stack datapath.
//
//  Channel   Direction  Handshake                  Payload
//  input     in         i_in_valid / o_in_ready    i_opcode, i_push_value
//  output    out        o_out_valid / i_out_ready  o_data, o_is_error, o_error_code, o_last
//
// Push and pop are done as the item is taken. Pint and add need a second step, as the
// stack memory has a registered read: entries are read as the item is taken, then
// printed or summed and written back. A pall of N entries shows its first result
// in the cycle after the item is taken, then one result per cycle while output is
// taken. An error result is held until taken, after which the block drops every item.
// Reset is synchronous and active low; it empties the stack and clears the halt.
// No new item is taken while a result is pending, so a stalled output stalls input.
module integer_stack_machine #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [2:0]                         i_opcode,
    input  logic signed [ism_pkg::DataW-1:0]   i_push_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [ism_pkg::DataW-1:0]   o_data,
    output logic                               o_is_error,
    output logic [2:0]                         o_error_code,
    output logic                               o_last
);

    ism_pkg::t_cmd                      cmd;
    ism_pkg::t_status                   status;
    logic signed [ism_pkg::DataW-1:0]   rd_data;

    // The controller decodes each item against the stack status and steers the datapath.
    ism_controller u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_status     (status),
        .o_cmd        (cmd),
        .o_is_error   (o_is_error),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

    // The datapath owns the stack memory, the entry count and the print pointer.
    ism_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_push_value (i_push_value),
        .o_status     (status),
        .o_rd_data    (rd_data)
    );

    // Error results carry zero data; otherwise the registered read data is shown.
    assign o_data = o_is_error ? '0 : rd_data;

endmodule

/* design/ism_checker.sv */
// Port-level assertion checker for the integer stack machine and its bind.
`include "integer_stack_machine_defines.svh"

module ism_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic signed [31:0]  o_data,
    input logic                o_is_error,
    input logic [2:0]          o_error_code,
    input logic                o_last
);

    logic err_valid;
    logic code_none;
    logic out_stall;

    assign err_valid = o_out_valid & o_is_error;
    assign code_none = (o_error_code == ism_pkg::ERR_NONE);
    assign out_stall = o_out_valid & !i_out_ready;

    // An error result is final, carries zero data and a real code.
    `ISM_ASSERT(a_err_shape, err_valid |-> (o_last && o_data == 32'sd0 && !code_none))

    // Ordinary results carry no error code.
    `ISM_ASSERT(a_ok_code, (o_out_valid && !o_is_error) |-> code_none)

    // Once an error result is taken, the machine is halted and shows nothing more.
    `ISM_ASSERT(a_halt_quiet, (err_valid && i_out_ready) |=> !o_out_valid)

    // No item is taken while a result is pending.
    `ISM_ASSERT(a_no_overlap, o_out_valid |-> !o_in_ready)

    // A stalled result holds its data.
    `ISM_ASSERT(a_out_hold, out_stall |=> (o_out_valid && $stable(o_data) && $stable(o_last)))

endmodule

bind integer_stack_machine ism_checker u_ism_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_data       (o_data),
    .o_is_error   (o_is_error),
    .o_error_code (o_error_code),
    .o_last       (o_last)
);

/* tb/sv/integer_stack_machine_tb.sv */
// Self-checking testbench of the integer stack machine: directed table, then random opcodes.
module integer_stack_machine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STACK_DEPTH  = 64;
    localparam int unsigned RESET_CYCLES = 11;
    localparam int unsigned ITEM_TARGET  = 430;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;

    // Opcodes that the engine drops without a result.
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    // One printed entry or error report, as the output port shows it.
    typedef struct packed {
        logic signed [31:0] data;
        logic               is_error;
        ism_pkg::t_err      code;
        logic               last;
    } t_result;

    // One row of the directed table. When typed is set, the single printed
    // entry of that row must equal want.
    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] val;
        logic               typed;
        logic signed [31:0] want;
    } t_row;

    typedef enum {RX_OPEN, RX_COIN, RX_CADENCE} t_rx_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_opcode;
    logic signed [31:0] i_push_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_data;
    logic               o_is_error;
    logic [2:0]         o_error_code;
    logic               o_last;

    // Mirror of the engine's state, advanced at every accepted item.
    logic signed [31:0] stack_mirror [STACK_DEPTH];
    int unsigned        depth_used    = 0;
    bit                 engine_halted = 1'b0;
    t_result            expected_results [$];

    int unsigned mismatch_count = 0;
    int unsigned counted_items  = 0;
    int unsigned burst_left     = 0;
    int unsigned cycle_count    = 0;

    // Directed opening: empty-stack pall, dropped opcodes, both extremes, sums that
    // cancel to zero or wrap past the negative extreme, and palls of one to three entries.
    localparam int DIR_ROWS = 25;
    localparam t_row DIRECTED [DIR_ROWS] = '{
        '{ism_pkg::OP_PALL, 32'h0000_1234, 1'b0, 32'h0},
        '{OP_UNUSED_LAST,   32'hFFFF_FFFF, 1'b0, 32'h0},
        '{OP_UNUSED_FIRST,  32'h0000_0001, 1'b0, 32'h0},
        '{ism_pkg::OP_PUSH, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{ism_pkg::OP_PINT, 32'hDEAD_BEEF, 1'b1, 32'h7FFF_FFFF},
        '{ism_pkg::OP_PUSH, 32'h8000_0000, 1'b0, 32'h0},
        '{ism_pkg::OP_PINT, 32'h0000_0000, 1'b1, 32'h8000_0000},
        '{ism_pkg::OP_ADD,  32'h0000_0001, 1'b0, 32'h0},
        '{ism_pkg::OP_PINT, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
        '{ism_pkg::OP_PUSH, 32'h0000_0001, 1'b0, 32'h0},
        '{ism_pkg::OP_ADD,  32'hFFFF_FFFF, 1'b0, 32'h0},
        '{ism_pkg::OP_PINT, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ism_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{ism_pkg::OP_PUSH, 32'h8000_0000, 1'b0, 32'h0},
        '{ism_pkg::OP_ADD,  32'h0000_0000, 1'b0, 32'h0},
        '{ism_pkg::OP_PINT, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
        '{ism_pkg::OP_PALL, 32'h0000_0007, 1'b0, 32'h0},
        '{ism_pkg::OP_POP,  32'h1234_5678, 1'b0, 32'h0},
        '{ism_pkg::OP_PALL, 32'h0000_0000, 1'b0, 32'h0},
        '{ism_pkg::OP_PUSH, 32'h5A5A_5A5A, 1'b0, 32'h0},
        '{ism_pkg::OP_PUSH, 32'hA5A5_A5A5, 1'b0, 32'h0},
        '{ism_pkg::OP_PALL, 32'h8000_0000, 1'b0, 32'h0},
        '{ism_pkg::OP_POP,  32'h0000_0000, 1'b0, 32'h0},
        '{ism_pkg::OP_POP,  32'h7FFF_FFFF, 1'b0, 32'h0},
        '{ism_pkg::OP_POP,  32'h0000_0000, 1'b0, 32'h0}
    };

    integer_stack_machine #(
        .DEPTH(STACK_DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_push_value(i_push_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data      (o_data),
        .o_is_error  (o_is_error),
        .o_error_code(o_error_code),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Any error leaves one error item behind and stops the engine for good.
    function automatic void halt_engine(ism_pkg::t_err code);
        engine_halted = 1'b1;
        expected_results.push_back('{32'sd0, 1'b1, code, 1'b1});
    endfunction

    // Advances the mirror by one opcode and queues the items it prints.
    function automatic void step_stack(logic [2:0] op, logic signed [31:0] val);
        if (engine_halted) return;
        case (op)
            ism_pkg::OP_PUSH: begin
                if (depth_used >= STACK_DEPTH) begin
                    halt_engine(ism_pkg::ERR_PUSH_FULL);
                end else begin
                    stack_mirror[depth_used] = val;
                    depth_used++;
                end
            end
            ism_pkg::OP_PALL: begin
                for (int i = depth_used; i > 0; i--)
                    expected_results.push_back('{stack_mirror[i-1], 1'b0, ism_pkg::ERR_NONE,
                                                 i == 1});
            end
            ism_pkg::OP_POP: begin
                if (depth_used == 0) halt_engine(ism_pkg::ERR_POP_EMPTY);
                else depth_used--;
            end
            ism_pkg::OP_PINT: begin
                if (depth_used == 0) begin
                    halt_engine(ism_pkg::ERR_PINT_EMPTY);
                end else begin
                    expected_results.push_back('{stack_mirror[depth_used-1], 1'b0,
                                                 ism_pkg::ERR_NONE, 1'b1});
                end
            end
            ism_pkg::OP_ADD: begin
                if (depth_used < 2) begin
                    halt_engine(ism_pkg::ERR_ADD_SHORT);
                end else begin
                    stack_mirror[depth_used-2] = stack_mirror[depth_used-1]
                                                 + stack_mirror[depth_used-2];
                    depth_used--;
                end
            end
            default: ;
        endcase
    endfunction

    // Push values lean toward the extremes and small numbers.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            4: return 32'($urandom_range(0, 15));
            default: return $urandom();
        endcase
    endfunction

    // An opcode that cannot fault at the current depth of the mirror.
    function automatic logic [2:0] pick_safe_op();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (depth_used == 0) return (roll < 85) ? ism_pkg::OP_PUSH : ism_pkg::OP_PALL;
        if (roll < 40 && depth_used < STACK_DEPTH) return ism_pkg::OP_PUSH;
        if (roll < 55) return ism_pkg::OP_PINT;
        if (roll < 70) return ism_pkg::OP_POP;
        if (roll < 85 && depth_used >= 2) return ism_pkg::OP_ADD;
        if (roll < 92) return ism_pkg::OP_PALL;
        return (depth_used < STACK_DEPTH) ? ism_pkg::OP_PUSH : ism_pkg::OP_POP;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offers one item and returns at the edge where it is taken. The sender
    // runs in bursts; a fresh burst may start after a gap with valid low.
    task automatic offer(input logic [2:0] op, input logic signed [31:0] val,
                         input logic typed = 1'b0, input logic signed [31:0] want = '0);
        int unsigned gap_len;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_len != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap_len) @(posedge i_clk);
            end
        end
        i_opcode     <= op;
        i_push_value <= val;
        i_in_valid   <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        step_stack(op, val);
        if (typed) expected_results[expected_results.size()-1].data = want;
        burst_left--;
        if (op <= ism_pkg::OP_ADD) counted_items++;
    endtask

    // Compares the item on the output port with the oldest expectation.
    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected item data %0d error %0b code %0d last %0b",
                                      o_data, o_is_error, o_error_code, o_last));
            return;
        end
        want = expected_results.pop_front();
        if (o_data !== want.data)
            report_mismatch($sformatf("data %0d, expected %0d", o_data, want.data));
        if (o_is_error !== want.is_error)
            report_mismatch($sformatf("is_error %0b, expected %0b", o_is_error, want.is_error));
        if (o_error_code !== want.code)
            report_mismatch($sformatf("error_code %0d, expected %0d", o_error_code, want.code));
        if (o_last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", o_last, want.last));
    endtask

    // Output side: checks every taken item and stalls on its own pattern.
    // Early on, and now and then after, it holds off for a long stretch so
    // that pending items back up into the input channel.
    initial begin : output_side
        int unsigned rx_cycle;
        int unsigned hold_left;
        t_rx_mode    mode;
        rx_cycle  = 0;
        hold_left = 0;
        mode      = RX_OPEN;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) check_result();
            rx_cycle++;
            if (rx_cycle == 400 || rx_cycle % 2500 == 0) hold_left = $urandom_range(150, 300);
            if (rx_cycle % 64 == 0) mode = t_rx_mode'($urandom_range(RX_OPEN, RX_CADENCE));
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:  i_out_ready <= 1'b1;
                    RX_COIN:  i_out_ready <= ($urandom_range(0, 2) != 0);
                    default:  i_out_ready <= (rx_cycle % 5 >= 2);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("integer_stack_machine_tb NOT OK");
            $finish;
        end
    end

    initial begin : input_side
        int unsigned   roll;
        ism_pkg::t_err fault;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_opcode     <= ism_pkg::OP_PUSH;
        i_push_value <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r])
            offer(DIRECTED[r].op, DIRECTED[r].val, DIRECTED[r].typed, DIRECTED[r].want);

        // Random part: mostly fault-free runs of opcodes, with the odd climb to
        // a full stack and a pall of every entry, unwinds toward empty, and
        // dropped opcodes as noise.
        while (counted_items < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                while (depth_used < STACK_DEPTH) offer(ism_pkg::OP_PUSH, pick_value());
                offer(ism_pkg::OP_PALL, $urandom());
            end else if (roll < 11) begin
                while (depth_used > 1)
                    offer(($urandom_range(0, 1) != 0) ? ism_pkg::OP_ADD : ism_pkg::OP_POP,
                          $urandom());
                if (depth_used == 1) offer(ism_pkg::OP_PINT, $urandom());
            end else if (roll < 17) begin
                offer(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), $urandom());
                if (depth_used == 0) offer(ism_pkg::OP_PALL, $urandom());
            end else begin
                repeat ($urandom_range(1, 12)) offer(pick_safe_op(), pick_value());
            end
        end

        // One fault can be seen per run, since only reset clears the halt.
        fault = ism_pkg::t_err'($urandom_range(ism_pkg::ERR_PINT_EMPTY,
                                               ism_pkg::ERR_PUSH_FULL));
        case (fault)
            ism_pkg::ERR_PUSH_FULL: begin
                while (depth_used < STACK_DEPTH) offer(ism_pkg::OP_PUSH, pick_value());
                offer(ism_pkg::OP_PUSH, pick_value());
            end
            ism_pkg::ERR_ADD_SHORT: begin
                while (depth_used > 1) offer(ism_pkg::OP_POP, $urandom());
                if (depth_used == 0 && $urandom_range(0, 1) != 0)
                    offer(ism_pkg::OP_PUSH, pick_value());
                offer(ism_pkg::OP_ADD, $urandom());
            end
            ism_pkg::ERR_POP_EMPTY: begin
                while (depth_used > 0) offer(ism_pkg::OP_POP, $urandom());
                offer(ism_pkg::OP_POP, $urandom());
            end
            default: begin
                while (depth_used > 0) offer(ism_pkg::OP_POP, $urandom());
                offer(ism_pkg::OP_PINT, $urandom());
            end
        endcase

        // The halted engine must drop everything that follows.
        repeat (6) offer(3'($urandom_range(ism_pkg::OP_PUSH, OP_UNUSED_LAST)), pick_value());
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("integer_stack_machine_tb OK");
        end else begin
            $display("integer_stack_machine_tb NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/ism_pkg.sv
design/ism_datapath.sv
design/ism_controller.sv
design/integer_stack_machine.sv
design/ism_checker.sv
tb/sv/integer_stack_machine_tb.sv
